// ===== rtl/core/uds_pkg.sv =====
// Shared types and constants of the UDS diagnostic server.
package uds_pkg;

   localparam logic [7:0] SID_READ_ID     = 8'h22;
   localparam logic [7:0] SID_SESSION     = 8'h10;
   localparam logic [7:0] SID_SECURITY    = 8'h27;
   localparam logic [7:0] SID_DOWNLOAD    = 8'h34;
   localparam logic [7:0] SID_TRANSFER    = 8'h36;
   localparam logic [7:0] SID_NEGATIVE    = 8'h7F;
   localparam logic [7:0] SID_POS_OFFSET  = 8'h40;

   localparam logic [7:0] NRC_SERVICE     = 8'h11;
   localparam logic [7:0] NRC_SUBFUNC     = 8'h12;
   localparam logic [7:0] NRC_CONDITIONS  = 8'h22;
   localparam logic [7:0] NRC_SEQUENCE    = 8'h24;
   localparam logic [7:0] NRC_RANGE       = 8'h31;
   localparam logic [7:0] NRC_INVALID_KEY = 8'h35;
   localparam logic [7:0] NRC_EXCEEDED    = 8'h36;

   localparam logic [7:0] DID_VIN_HI      = 8'hF1;
   localparam logic [7:0] DID_VIN_LO      = 8'h90;
   localparam logic [7:0] DID_PIN_A0_HI   = 8'h91;
   localparam logic [7:0] DID_PIN_A2_HI   = 8'h92;
   localparam logic [7:0] DID_PIN_LO      = 8'hA0;

   localparam logic [7:0] SEC_SEED        = 8'h01;
   localparam logic [7:0] SEC_KEY         = 8'h02;
   localparam logic [7:0] DL_BLOCK_LEN    = 8'd20;

   localparam logic [1:0] SESSION_DEFAULT = 2'd0;
   localparam logic [1:0] SESSION_PROG    = 2'd2;

   localparam logic [1:0] CSR_SEED        = 2'd0;
   localparam logic [1:0] CSR_KEY         = 2'd1;
   localparam logic [1:0] CSR_LIMIT       = 2'd2;

   localparam logic [15:0] SEED_RESET     = 16'h1234;
   localparam logic [15:0] KEY_RESET      = 16'h1239;
   localparam logic [3:0]  LIMIT_RESET    = 4'd5;

   typedef struct packed {
      logic [15:0] seed_value;
      logic [15:0] expected_key;
      logic [3:0]  attempt_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] sid;
      logic [7:0] sub_function;
      logic [7:0] third_byte;
      logic [7:0] fourth_byte;
      logic       pin_a0_level;
      logic       pin_a2_level;
   } req_type;

   typedef struct packed {
      logic [2:0] resp_len;
      logic [7:0] resp_byte0;
      logic [7:0] resp_byte1;
      logic [7:0] resp_byte2;
      logic [7:0] resp_byte3;
      logic [1:0] session_now;
      logic       locked_now;
      logic       download_open;
   } rsp_type;

endpackage

// ===== rtl/core/uds_if.sv =====
// Request and response channel interfaces of the UDS diagnostic server.
interface uds_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  sid;
   logic [7:0]  sub_function;
   logic [7:0]  third_byte;
   logic [7:0]  fourth_byte;
   logic [31:0] memory_address;
   logic [31:0] memory_size;
   logic        pin_a0_level;
   logic        pin_a2_level;

   modport source (output valid, sid, sub_function, third_byte, fourth_byte,
                   memory_address, memory_size, pin_a0_level, pin_a2_level,
                   input ready);
   modport sink (input valid, sid, sub_function, third_byte, fourth_byte,
                 memory_address, memory_size, pin_a0_level, pin_a2_level,
                 output ready);
endinterface

interface uds_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] resp_len;
   logic [7:0] resp_byte0;
   logic [7:0] resp_byte1;
   logic [7:0] resp_byte2;
   logic [7:0] resp_byte3;
   logic [1:0] session_now;
   logic       locked_now;
   logic       download_open;

   modport source (output valid, resp_len, resp_byte0, resp_byte1, resp_byte2,
                   resp_byte3, session_now, locked_now, download_open,
                   input ready);
   modport sink (input valid, resp_len, resp_byte0, resp_byte1, resp_byte2,
                 resp_byte3, session_now, locked_now, download_open,
                 output ready);
endinterface

// ===== rtl/core/uds_csr.sv =====
// Configuration registers: seed, expected key and attempt limit.
module uds_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output uds_pkg::cfg_type  cfg
);

   uds_pkg::cfg_type cfg_ff;
   uds_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            uds_pkg::CSR_SEED:  cfg_in.seed_value    = csr_wdata;
            uds_pkg::CSR_KEY:   cfg_in.expected_key  = csr_wdata;
            uds_pkg::CSR_LIMIT: cfg_in.attempt_limit = csr_wdata[3:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed_value    <= uds_pkg::SEED_RESET;
         cfg_ff.expected_key  <= uds_pkg::KEY_RESET;
         cfg_ff.attempt_limit <= uds_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/uds_decode.sv =====
// Service decoder and session, security and download state.
module uds_decode (
   input  logic              clock,
   input  logic              reset,
   input  uds_pkg::cfg_type  cfg,
   input  uds_pkg::req_type  item,
   input  logic              step,
   output uds_pkg::rsp_type  rsp,
   output logic              has_rsp
);

   logic [1:0] session_ff,  session_in;
   logic       locked_ff,   locked_in;
   logic       pending_ff,  pending_in;
   logic [3:0] failed_ff,   failed_in;
   logic       dl_ff,       dl_in;
   uds_pkg::rsp_type r;

   always_comb begin
      session_in = session_ff;
      locked_in  = locked_ff;
      pending_in = pending_ff;
      failed_in  = failed_ff;
      dl_in      = dl_ff;
      has_rsp    = 1'b0;
      r          = '0;
      if (!item.sid[6]) begin
         has_rsp = 1'b1;
         r.resp_len   = 3'd3;
         r.resp_byte0 = uds_pkg::SID_NEGATIVE;
         r.resp_byte1 = item.sid;
         case (item.sid)
            uds_pkg::SID_READ_ID: begin
               r.resp_byte2 = uds_pkg::NRC_RANGE;
               if (item.sub_function == uds_pkg::DID_VIN_HI &&
                   item.third_byte == uds_pkg::DID_VIN_LO) begin
                  r.resp_byte0 = uds_pkg::SID_READ_ID + uds_pkg::SID_POS_OFFSET;
                  r.resp_byte1 = uds_pkg::DID_VIN_HI;
                  r.resp_byte2 = uds_pkg::DID_VIN_LO;
               end else if (item.third_byte == uds_pkg::DID_PIN_LO &&
                            (item.sub_function == uds_pkg::DID_PIN_A0_HI ||
                             item.sub_function == uds_pkg::DID_PIN_A2_HI)) begin
                  r.resp_len   = 3'd4;
                  r.resp_byte0 = uds_pkg::SID_READ_ID + uds_pkg::SID_POS_OFFSET;
                  r.resp_byte1 = item.sub_function;
                  r.resp_byte2 = uds_pkg::DID_PIN_LO;
                  r.resp_byte3 = {7'd0, (item.sub_function == uds_pkg::DID_PIN_A0_HI) ?
                                 item.pin_a0_level : item.pin_a2_level};
               end
            end
            uds_pkg::SID_SESSION: begin
               if (item.sub_function inside {[8'd1 : 8'd3]}) begin
                  session_in   = item.sub_function[1:0] - 2'd1;
                  locked_in    = 1'b1;
                  r.resp_len   = 3'd2;
                  r.resp_byte0 = uds_pkg::SID_SESSION + uds_pkg::SID_POS_OFFSET;
                  r.resp_byte1 = item.sub_function;
               end else begin
                  r.resp_byte2 = uds_pkg::NRC_SUBFUNC;
               end
            end
            uds_pkg::SID_SECURITY: begin
               r.resp_byte2 = uds_pkg::NRC_CONDITIONS;
               if (item.sub_function == uds_pkg::SEC_SEED) begin
                  if (session_ff == uds_pkg::SESSION_PROG) begin
                     locked_in    = 1'b1;
                     pending_in   = 1'b1;
                     r.resp_len   = 3'd4;
                     r.resp_byte0 = uds_pkg::SID_SECURITY + uds_pkg::SID_POS_OFFSET;
                     r.resp_byte1 = uds_pkg::SEC_SEED;
                     r.resp_byte2 = cfg.seed_value[15:8];
                     r.resp_byte3 = cfg.seed_value[7:0];
                  end
               end else if (item.sub_function == uds_pkg::SEC_KEY) begin
                  if (!pending_ff) begin
                     r.resp_byte2 = uds_pkg::NRC_SEQUENCE;
                  end else if ({item.third_byte, item.fourth_byte} == cfg.expected_key) begin
                     pending_in   = 1'b0;
                     locked_in    = 1'b0;
                     failed_in    = 4'd0;
                     r.resp_len   = 3'd2;
                     r.resp_byte0 = uds_pkg::SID_SECURITY + uds_pkg::SID_POS_OFFSET;
                     r.resp_byte1 = uds_pkg::SEC_KEY;
                     r.resp_byte2 = 8'd0;
                  end else if (failed_ff < cfg.attempt_limit) begin
                     failed_in    = failed_ff + 4'd1;
                     r.resp_byte2 = uds_pkg::NRC_INVALID_KEY;
                  end else begin
                     failed_in    = 4'd0;
                     r.resp_byte2 = uds_pkg::NRC_EXCEEDED;
                  end
               end
            end
            uds_pkg::SID_DOWNLOAD: begin
               r.resp_byte2 = uds_pkg::NRC_CONDITIONS;
               if (session_ff == uds_pkg::SESSION_PROG) begin
                  if (!pending_ff && !locked_ff) begin
                     dl_in        = 1'b1;
                     r.resp_len   = 3'd2;
                     r.resp_byte0 = uds_pkg::SID_DOWNLOAD + uds_pkg::SID_POS_OFFSET;
                     r.resp_byte1 = uds_pkg::DL_BLOCK_LEN;
                     r.resp_byte2 = 8'd0;
                  end else begin
                     has_rsp = 1'b0;
                  end
               end
            end
            uds_pkg::SID_TRANSFER: begin
               has_rsp = 1'b0;
            end
            default: begin
               r.resp_byte2 = uds_pkg::NRC_SERVICE;
            end
         endcase
      end
      r.session_now   = session_in;
      r.locked_now    = locked_in;
      r.download_open = dl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         session_ff <= uds_pkg::SESSION_DEFAULT;
         locked_ff  <= 1'b1;
         pending_ff <= 1'b0;
         failed_ff  <= 4'd0;
         dl_ff      <= 1'b0;
      end else if (step) begin
         session_ff <= session_in;
         locked_ff  <= locked_in;
         pending_ff <= pending_in;
         failed_ff  <= failed_in;
         dl_ff      <= dl_in;
      end
   end

   assign rsp = r;

endmodule

// ===== rtl/core/uds_diagnostic_server.sv =====
// Top level of the UDS diagnostic server: request register, decoder, response register.
//
// One decoded diagnostic request enters on the req channel as an item; at most one
// response item of two to four bytes leaves on the rsp channel, together with the
// session, lock and download state after that request. Requests with sid bit 0x40
// set, transfer data, and download requests refused in the programming session while
// locked or with a seed pending give no response item.
// The csr port writes the seed, the expected key and the attempt limit; the user must
// see that it is written only while no request is in flight, as the block does not enforce it.
// A request is taken into the request register at the edge it is accepted, decoded
// combinationally from that register, and its response enters the response register
// when the decoder steps. One request per cycle is sustained while the receiver
// takes responses; the single decode stage between the two registers sets that rate.
// When the receiver stalls, the response register holds its item and the request
// register holds one more; req.ready falls only when both are full and the held
// request would produce a response. Reset empties both registers, returns the
// session to default, locks security, clears the seed flag, the failed-key count
// and the download window, and loads the register reset values.
module uds_diagnostic_server (
   input  logic         clock,
   input  logic         reset,
   uds_req_if.sink      req,
   uds_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   uds_pkg::cfg_type cfg;
   uds_pkg::req_type item_ff, item_in;
   logic             item_valid_ff, item_valid_in;
   uds_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   uds_pkg::rsp_type dec_rsp;
   logic             dec_has_rsp;
   logic             out_free;
   logic             step;
   logic             take;

   uds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uds_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item_ff),
      .step    (step),
      .rsp     (dec_rsp),
      .has_rsp (dec_has_rsp)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign step      = item_valid_ff && (out_free || !dec_has_rsp);
   assign req.ready = !item_valid_ff || step;
   assign take      = req.valid && req.ready;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !step;
      if (take) begin
         item_valid_in        = 1'b1;
         item_in.sid          = req.sid;
         item_in.sub_function = req.sub_function;
         item_in.third_byte   = req.third_byte;
         item_in.fourth_byte  = req.fourth_byte;
         item_in.pin_a0_level = req.pin_a0_level;
         item_in.pin_a2_level = req.pin_a2_level;
      end
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (step && dec_has_rsp) begin
         out_in       = dec_rsp;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.resp_len      = out_ff.resp_len;
   assign rsp.resp_byte0    = out_ff.resp_byte0;
   assign rsp.resp_byte1    = out_ff.resp_byte1;
   assign rsp.resp_byte2    = out_ff.resp_byte2;
   assign rsp.resp_byte3    = out_ff.resp_byte3;
   assign rsp.session_now   = out_ff.session_now;
   assign rsp.locked_now    = out_ff.locked_now;
   assign rsp.download_open = out_ff.download_open;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.resp_len == 3'd2 || rsp.resp_len == 3'd3 || rsp.resp_len == 3'd4))
      else $error("response length out of range");

   a_negative_len: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.resp_byte0 == uds_pkg::SID_NEGATIVE |-> rsp.resp_len == 3'd3)
      else $error("negative response with wrong length");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && dec_has_rsp && !out_free |=> item_valid_ff)
      else $error("pending request dropped while response stalled");

endmodule

// ===== tb/sv/uds_diagnostic_server_tb.sv =====
// Testbench of the UDS diagnostic server: directed and random requests checked against a predictor.
module uds_diagnostic_server_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_REQUESTS = 750;
   localparam int PHASES          = 8;
   localparam int MAX_REPORTS     = 10;

   localparam logic [7:0] NRC_NONE        = 8'h00;
   localparam logic [7:0] SUB_DEFAULT     = 8'h01;
   localparam logic [7:0] SUB_EXTENDED    = 8'h02;
   localparam logic [7:0] SUB_PROGRAMMING = 8'h03;

   typedef struct packed {
      logic [7:0]  sid;
      logic [7:0]  sub_function;
      logic [7:0]  third_byte;
      logic [7:0]  fourth_byte;
      logic [31:0] memory_address;
      logic [31:0] memory_size;
      logic        pin_a0_level;
      logic        pin_a2_level;
   } diag_request_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   uds_req_if req ();
   uds_rsp_if rsp ();

   uds_diagnostic_server i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uds_pkg::cfg_type cfg        = '{uds_pkg::SEED_RESET, uds_pkg::KEY_RESET,
                                    uds_pkg::LIMIT_RESET};
   logic [1:0]  session_state   = uds_pkg::SESSION_DEFAULT;
   logic        security_locked = 1'b1;
   logic        seed_issued     = 1'b0;
   logic [3:0]  wrong_key_count = 4'd0;
   logic        window_open     = 1'b0;
   logic [31:0] window_base     = 32'd0;
   logic [31:0] window_size     = 32'd0;

   uds_pkg::rsp_type answers_due[$];
   bit      req_held;
   int      idle_pct;
   int      stall_pct;
   int      requests_sent;
   int      responses_checked;
   int      failures;
   int      idle_cycles;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic bit server_answer(input diag_request_type q,
                                        output uds_pkg::rsp_type a);
      logic [7:0] nrc;
      bit         answered;
      nrc = NRC_NONE;
      answered = 1'b1;
      a = '0;
      a.resp_byte0 = q.sid + uds_pkg::SID_POS_OFFSET;
      a.resp_byte1 = q.sub_function;
      if ((q.sid & uds_pkg::SID_POS_OFFSET) != 8'h00) begin
         answered = 1'b0;
      end else begin
         case (q.sid)
            uds_pkg::SID_READ_ID: begin
               a.resp_byte2 = q.third_byte;
               if (q.sub_function == uds_pkg::DID_VIN_HI &&
                   q.third_byte == uds_pkg::DID_VIN_LO) begin
                  a.resp_len = 3'd3;
               end else if (q.sub_function == uds_pkg::DID_PIN_A0_HI &&
                            q.third_byte == uds_pkg::DID_PIN_LO) begin
                  a.resp_len = 3'd4;
                  a.resp_byte3 = {7'd0, q.pin_a0_level};
               end else if (q.sub_function == uds_pkg::DID_PIN_A2_HI &&
                            q.third_byte == uds_pkg::DID_PIN_LO) begin
                  a.resp_len = 3'd4;
                  a.resp_byte3 = {7'd0, q.pin_a2_level};
               end else begin
                  nrc = uds_pkg::NRC_RANGE;
               end
            end
            uds_pkg::SID_SESSION: begin
               if (q.sub_function >= SUB_DEFAULT && q.sub_function <= SUB_PROGRAMMING) begin
                  session_state = q.sub_function[1:0] - 2'd1;
                  security_locked = 1'b1;
                  a.resp_len = 3'd2;
               end else begin
                  nrc = uds_pkg::NRC_SUBFUNC;
               end
            end
            uds_pkg::SID_SECURITY: begin
               if (q.sub_function == uds_pkg::SEC_SEED) begin
                  if (session_state != uds_pkg::SESSION_PROG) begin
                     nrc = uds_pkg::NRC_CONDITIONS;
                  end else begin
                     security_locked = 1'b1;
                     seed_issued = 1'b1;
                     a.resp_len = 3'd4;
                     {a.resp_byte2, a.resp_byte3} = cfg.seed_value;
                  end
               end else if (q.sub_function == uds_pkg::SEC_KEY) begin
                  if (!seed_issued) begin
                     nrc = uds_pkg::NRC_SEQUENCE;
                  end else if ({q.third_byte, q.fourth_byte} == cfg.expected_key) begin
                     seed_issued = 1'b0;
                     security_locked = 1'b0;
                     wrong_key_count = 4'd0;
                     a.resp_len = 3'd2;
                  end else if (wrong_key_count < cfg.attempt_limit) begin
                     wrong_key_count = wrong_key_count + 4'd1;
                     nrc = uds_pkg::NRC_INVALID_KEY;
                  end else begin
                     wrong_key_count = 4'd0;
                     nrc = uds_pkg::NRC_EXCEEDED;
                  end
               end else begin
                  nrc = uds_pkg::NRC_CONDITIONS;
               end
            end
            uds_pkg::SID_DOWNLOAD: begin
               if (session_state != uds_pkg::SESSION_PROG) begin
                  nrc = uds_pkg::NRC_CONDITIONS;
               end else if (!seed_issued && !security_locked) begin
                  window_open = 1'b1;
                  window_base = q.memory_address;
                  window_size = q.memory_size;
                  a.resp_len = 3'd2;
                  a.resp_byte1 = uds_pkg::DL_BLOCK_LEN;
               end else begin
                  answered = 1'b0;
               end
            end
            uds_pkg::SID_TRANSFER: begin
               answered = 1'b0;
            end
            default: begin
               nrc = uds_pkg::NRC_SERVICE;
            end
         endcase
      end
      if (nrc != NRC_NONE) begin
         a.resp_len = 3'd3;
         a.resp_byte0 = uds_pkg::SID_NEGATIVE;
         a.resp_byte1 = q.sid;
         a.resp_byte2 = nrc;
         a.resp_byte3 = 8'h00;
      end else if (a.resp_len == 3'd2) begin
         a.resp_byte2 = 8'h00;
         a.resp_byte3 = 8'h00;
      end
      a.session_now = session_state;
      a.locked_now = security_locked;
      a.download_open = window_open;
      return answered;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic diag_request_type request_of(input logic [7:0] sid, sub, third,
                                                   fourth);
      diag_request_type q;
      q.sid = sid;
      q.sub_function = sub;
      q.third_byte = third;
      q.fourth_byte = fourth;
      q.memory_address = $urandom;
      q.memory_size = $urandom;
      q.pin_a0_level = 1'($urandom_range(1));
      q.pin_a2_level = 1'($urandom_range(1));
      return q;
   endfunction

   function automatic string describe(input uds_pkg::rsp_type r);
      return $sformatf("len %0d bytes %h %h %h %h session %0d locked %b download %b",
                       r.resp_len, r.resp_byte0, r.resp_byte1, r.resp_byte2,
                       r.resp_byte3, r.session_now, r.locked_now, r.download_open);
   endfunction

   task automatic send_request(input diag_request_type q);
      uds_pkg::rsp_type a;
      req.valid <= 1'b1;
      req.sid <= q.sid;
      req.sub_function <= q.sub_function;
      req.third_byte <= q.third_byte;
      req.fourth_byte <= q.fourth_byte;
      req.memory_address <= q.memory_address;
      req.memory_size <= q.memory_size;
      req.pin_a0_level <= q.pin_a0_level;
      req.pin_a2_level <= q.pin_a2_level;
      req_held = 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (server_answer(q, a)) answers_due.push_back(a);
      requests_sent++;
      while ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle();
      if (req_held) begin
         req.valid <= 1'b0;
         req_held = 1'b0;
      end
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] seed, key, input logic [3:0] limit);
      settle();
      csr_we <= 1'b1;
      csr_index <= uds_pkg::CSR_SEED;
      csr_wdata <= seed;
      @(posedge clock);
      csr_index <= uds_pkg::CSR_KEY;
      csr_wdata <= key;
      @(posedge clock);
      csr_index <= uds_pkg::CSR_LIMIT;
      csr_wdata <= {12'd0, limit};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg.seed_value = seed;
      cfg.expected_key = key;
      cfg.attempt_limit = limit;
   endtask

   task automatic test_unknown_and_ignored();
      send_request(request_of(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_request(request_of(8'h62, uds_pkg::DID_VIN_HI, uds_pkg::DID_VIN_LO, 8'h00));
      send_request(request_of(8'h00, 8'h00, 8'h00, 8'h00));
      send_request(request_of(8'h80, 8'h01, 8'h02, 8'h03));
      send_request(request_of(uds_pkg::SID_TRANSFER, 8'h01, 8'hFF, 8'h00));
   endtask

   task automatic test_read_identifiers();
      diag_request_type q;
      send_request(request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_VIN_HI,
                              uds_pkg::DID_VIN_LO, 8'h00));
      q = request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_PIN_A0_HI, uds_pkg::DID_PIN_LO, 8'h00);
      q.pin_a0_level = 1'b1;
      q.pin_a2_level = 1'b0;
      send_request(q);
      q = request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_PIN_A2_HI, uds_pkg::DID_PIN_LO, 8'h00);
      q.pin_a0_level = 1'b0;
      q.pin_a2_level = 1'b1;
      send_request(q);
      send_request(request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_VIN_HI,
                              uds_pkg::DID_PIN_LO, 8'h00));
   endtask

   task automatic test_session_control();
      send_request(request_of(uds_pkg::SID_SESSION, 8'h00, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SESSION, 8'hFF, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SESSION, SUB_EXTENDED, 8'h00, 8'h00));
   endtask

   task automatic test_security_access();
      diag_request_type q;
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_SEED, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h12, 8'h39));
      send_request(request_of(uds_pkg::SID_SECURITY, 8'h03, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SESSION, SUB_PROGRAMMING, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_SEED, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_DOWNLOAD, 8'h00, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00));
      set_config(16'hFFFF, 16'h0000, 4'd1);
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'hFF, 8'hFF));
      send_request(request_of(uds_pkg::SID_SESSION, SUB_PROGRAMMING, 8'h00, 8'h00));
      q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00);
      send_request(q);
   endtask

   task automatic test_download_window();
      diag_request_type q;
      q = request_of(uds_pkg::SID_DOWNLOAD, 8'h00, 8'h00, 8'h00);
      q.memory_address = 32'hFFFF_FFFF;
      q.memory_size = 32'h0000_0000;
      send_request(q);
      send_request(request_of(uds_pkg::SID_SESSION, SUB_EXTENDED, 8'h00, 8'h00));
      q = request_of(uds_pkg::SID_DOWNLOAD, 8'hFF, 8'hFF, 8'hFF);
      q.memory_address = 32'h0000_0000;
      q.memory_size = 32'hFFFF_FFFF;
      send_request(q);
      send_request(request_of(uds_pkg::SID_SESSION, SUB_PROGRAMMING, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_DOWNLOAD, 8'h00, 8'h00, 8'h00));
   endtask

   task automatic test_zero_attempt_limit();
      set_config(16'h0000, 16'hFFFF, 4'd0);
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_SEED, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00));
      send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'hFF, 8'hFE));
   endtask

   task automatic test_random_traffic();
      diag_request_type q;
      int phase;
      int quota;
      int pick;
      int wrong;
      int k;
      int send_idle[4]  = '{0, 63, 0, 11};
      int recv_stall[4] = '{0, 0, 63, 11};
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_config(uds_pkg::SEED_RESET, uds_pkg::KEY_RESET, uds_pkg::LIMIT_RESET);
            1: set_config(16'hFFFF, 16'hFFFF, 4'd15);
            2: set_config(16'h0000, 16'h0000, 4'd1);
            4: set_config(16'h0000, 16'hFFFF, 4'd15);
            5: set_config(16'hFFFF, 16'h0000, 4'd1);
            default: set_config(16'($urandom), 16'($urandom), 4'($urandom_range(15, 1)));
         endcase
         idle_pct = send_idle[phase % 4];
         stall_pct = recv_stall[phase % 4];
         quota = requests_sent + RANDOM_REQUESTS / PHASES;
         while (requests_sent < quota) begin
            if ($urandom_range(49) == 0) settle();
            pick = $urandom_range(99);
            if (pick < 12) begin
               send_request(request_of(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
            end else if (pick < 22) begin
               case ($urandom_range(3))
                  0: q = request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_VIN_HI,
                                    uds_pkg::DID_VIN_LO, rand_byte());
                  1: q = request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_PIN_A0_HI,
                                    uds_pkg::DID_PIN_LO, rand_byte());
                  2: q = request_of(uds_pkg::SID_READ_ID, uds_pkg::DID_PIN_A2_HI,
                                    uds_pkg::DID_PIN_LO, rand_byte());
                  default: q = request_of(uds_pkg::SID_READ_ID, rand_byte(), rand_byte(),
                                          rand_byte());
               endcase
               send_request(q);
            end else if (pick < 32) begin
               if ($urandom_range(4) == 0)
                  q = request_of(uds_pkg::SID_SESSION, rand_byte(), rand_byte(), rand_byte());
               else
                  q = request_of(uds_pkg::SID_SESSION, 8'($urandom_range(3, 1)), rand_byte(),
                                 rand_byte());
               send_request(q);
            end else if (pick < 58) begin
               send_request(request_of(uds_pkg::SID_SESSION, SUB_PROGRAMMING, rand_byte(),
                                       rand_byte()));
               send_request(request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_SEED, rand_byte(),
                                       rand_byte()));
               if ($urandom_range(3) == 0) wrong = $urandom_range(cfg.attempt_limit + 2);
               else wrong = $urandom_range(1);
               for (k = 0; k < wrong; k++) begin
                  q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00);
                  {q.third_byte, q.fourth_byte} = cfg.expected_key ^ 16'($urandom_range(65535, 1));
                  send_request(q);
               end
               if ($urandom_range(4) != 0) begin
                  q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00);
                  {q.third_byte, q.fourth_byte} = cfg.expected_key;
                  send_request(q);
               end
               send_request(request_of(uds_pkg::SID_DOWNLOAD, rand_byte(), rand_byte(),
                                       rand_byte()));
               wrong = $urandom_range(3);
               for (k = 0; k < wrong; k++)
                  send_request(request_of(uds_pkg::SID_TRANSFER, rand_byte(), rand_byte(),
                                          rand_byte()));
            end else if (pick < 72) begin
               case ($urandom_range(3))
                  0: q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_SEED, rand_byte(),
                                    rand_byte());
                  1: begin
                     q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, 8'h00, 8'h00);
                     {q.third_byte, q.fourth_byte} = cfg.expected_key;
                  end
                  2: q = request_of(uds_pkg::SID_SECURITY, uds_pkg::SEC_KEY, rand_byte(),
                                    rand_byte());
                  default: q = request_of(uds_pkg::SID_SECURITY, rand_byte(), rand_byte(),
                                          rand_byte());
               endcase
               send_request(q);
            end else if (pick < 84) begin
               send_request(request_of(uds_pkg::SID_DOWNLOAD, rand_byte(), rand_byte(),
                                       rand_byte()));
            end else if (pick < 92) begin
               send_request(request_of(uds_pkg::SID_TRANSFER, rand_byte(), rand_byte(),
                                       rand_byte()));
            end else begin
               send_request(request_of(rand_byte() | uds_pkg::SID_POS_OFFSET, rand_byte(),
                                       rand_byte(), rand_byte()));
            end
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin : check_responses
      uds_pkg::rsp_type got;
      uds_pkg::rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.resp_len, rsp.resp_byte0, rsp.resp_byte1, rsp.resp_byte2,
                 rsp.resp_byte3, rsp.session_now, rsp.locked_now, rsp.download_open};
         responses_checked++;
         if (answers_due.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("%0t: response with none outstanding: %s", $time, describe(got));
            failures++;
         end else begin
            want = answers_due.pop_front();
            if (got.resp_len !== want.resp_len || got.resp_byte0 !== want.resp_byte0 ||
                got.resp_byte1 !== want.resp_byte1 || got.resp_byte2 !== want.resp_byte2 ||
                got.resp_byte3 !== want.resp_byte3 || got.session_now !== want.session_now ||
                got.locked_now !== want.locked_now ||
                got.download_open !== want.download_open) begin
               if (failures < MAX_REPORTS) begin
                  $display("%0t: response mismatch", $time);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= uds_pkg::CSR_SEED;
      csr_wdata <= 16'h0000;
      req.valid <= 1'b0;
      req.sid <= 8'h00;
      req.sub_function <= 8'h00;
      req.third_byte <= 8'h00;
      req.fourth_byte <= 8'h00;
      req.memory_address <= 32'h0;
      req.memory_size <= 32'h0;
      req.pin_a0_level <= 1'b0;
      req.pin_a2_level <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_unknown_and_ignored();
      test_read_identifiers();
      test_session_control();
      test_security_access();
      test_download_window();
      test_zero_attempt_limit();
      test_random_traffic();
      settle();
      $display("Sent %0d requests and checked %0d responses", requests_sent,
               responses_checked);
      $display("across %0d register settings and four idle and stall mixes.", PHASES + 2);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures.", failures);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
